// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 80;
  localparam int unsigned SCREEN_HEIGHT_DEF = 25;

  localparam int unsigned CELL_W  = 16;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned OFF_W   = 11;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h02;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;             // item accepted and executed at this edge
    logic copy_step;        // one step of the scroll copy sweep
    logic fill_step;        // one blank write of a fill sweep
    logic fill_reset_color; // fill with the reset attribute (power-up pass)
    logic cap_read;         // capture the read data of a read item
    logic load_out;         // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;          // operation of the item at the input
    logic will_scroll; // the item at the input pushes the cursor off the bottom
    logic copy_last;   // the copy sweep is at its final write
    logic fill_last;   // the fill sweep is at the last cell
  } status_t;

endpackage

// ----- rtl/tcw_datapath.sv -----
// Datapath of the text console writer: cell store, cursor, sweep counter and result register.
module tcw_datapath #(
  parameter int unsigned SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tcw_pkg::cmd_t                cmd,
  output tcw_pkg::status_t             status,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata,
  input  logic [tcw_pkg::OP_W-1:0]     op,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::POS_W-1:0]    pos_x,
  input  logic [tcw_pkg::POS_W-1:0]    pos_y,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]    cursor_offset,
  output logic                         scrolled
);

  localparam int unsigned CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(SCREEN_WIDTH);
  localparam int unsigned RW    = $clog2(SCREEN_HEIGHT);

  localparam logic [AW-1:0] W_A        = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] COPY_END   = AW'(CELLS - SCREEN_WIDTH);
  localparam logic [AW-1:0] FILL_END   = AW'(CELLS - 1);
  localparam logic [CW-1:0] COL_LAST   = CW'(SCREEN_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST   = RW'(SCREEN_HEIGHT - 1);
  localparam logic [tcw_pkg::POS_W-1:0] X_LIM = tcw_pkg::POS_W'(SCREEN_WIDTH - 1);
  localparam logic [tcw_pkg::POS_W-1:0] Y_LIM = tcw_pkg::POS_W'(SCREEN_HEIGHT - 1);

  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]  rdata;

  logic [tcw_pkg::COLOR_W-1:0] text_color;
  logic [CW-1:0]               cur_col;
  logic [RW-1:0]               cur_row;
  logic [CW-1:0]               cur_col_next;
  logic [RW-1:0]               cur_row_next;
  logic [AW-1:0]               cnt;
  logic [tcw_pkg::CELL_W-1:0]  res_cell;
  logic                        res_scrolled;

  tcw_pkg::op_t                op_e;
  logic                        is_newline;
  logic                        wraps;
  logic [CW-1:0]               clamp_x;
  logic [RW-1:0]               clamp_y;
  logic [AW-1:0]               cur_addr;
  logic [AW-1:0]               read_addr;
  logic [tcw_pkg::CELL_W-1:0]  put_cell;
  logic [tcw_pkg::COLOR_W-1:0] fill_color;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [tcw_pkg::CELL_W-1:0]  wdata;
  logic                        re;
  logic [AW-1:0]               raddr;

  assign op_e       = tcw_pkg::op_t'(op);
  assign is_newline = (char_code == tcw_pkg::NEWLINE_CODE);
  // The cursor leaves its row on a newline or after writing the last column.
  assign wraps      = is_newline || (cur_col == COL_LAST);

  assign clamp_x   = (pos_x > X_LIM) ? CW'(X_LIM) : CW'(pos_x);
  assign clamp_y   = (pos_y > Y_LIM) ? RW'(Y_LIM) : RW'(pos_y);
  assign cur_addr  = AW'(cur_row) * W_A + AW'(cur_col);
  assign read_addr = AW'(clamp_y) * W_A + AW'(clamp_x);
  assign put_cell  = {text_color, char_code};
  assign fill_color = cmd.fill_reset_color ? tcw_pkg::RESET_COLOR : text_color;

  assign status.op          = op_e;
  assign status.will_scroll = (op_e == tcw_pkg::OP_PUT) && wraps && (cur_row == ROW_LAST);
  assign status.copy_last   = (cnt == COPY_END);
  assign status.fill_last   = (cnt == FILL_END);

  // Cursor update at the execute edge.
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (cmd.exec) begin
      unique case (op_e)
        tcw_pkg::OP_PUT: begin
          if (wraps) begin
            cur_col_next = '0;
            cur_row_next = (cur_row == ROW_LAST) ? ROW_LAST : cur_row + RW'(1);
          end else begin
            cur_col_next = cur_col + CW'(1);
          end
        end
        tcw_pkg::OP_MOVE: begin
          cur_col_next = clamp_x;
          cur_row_next = clamp_y;
        end
        tcw_pkg::OP_CLEAR, tcw_pkg::OP_READ: begin
          cur_col_next = cur_col;
          cur_row_next = cur_row;
        end
        default: begin
          cur_col_next = cur_col;
          cur_row_next = cur_row;
        end
      endcase
    end
  end

  // Memory port selection. The copy sweep reads a row ahead and writes one cell behind.
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = put_cell;
    priority if (cmd.exec && (op_e == tcw_pkg::OP_PUT) && !is_newline) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = put_cell;
    end else if (cmd.copy_step && (cnt != '0)) begin
      we    = 1'b1;
      waddr = cnt - AW'(1);
      wdata = rdata;
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = {fill_color, tcw_pkg::BLANK_CHAR};
    end else begin
      we    = 1'b0;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = read_addr;
    priority if (cmd.exec && (op_e == tcw_pkg::OP_READ)) begin
      re    = 1'b1;
      raddr = read_addr;
    end else if (cmd.copy_step && !status.copy_last) begin
      re    = 1'b1;
      raddr = cnt + W_A;
    end else begin
      re    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
      cur_col    <= '0;
      cur_row    <= '0;
      cnt        <= '0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      if (cmd.exec) begin
        cnt <= '0;
      end else if ((cmd.copy_step && !status.copy_last) ||
                   (cmd.fill_step && !status.fill_last)) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  // Result and output registers carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_cell     <= ((op_e == tcw_pkg::OP_PUT) && !is_newline) ? put_cell : '0;
      res_scrolled <= status.will_scroll;
    end else if (cmd.cap_read) begin
      res_cell     <= rdata;
    end
    if (cmd.load_out) begin
      cell_data     <= res_cell;
      cursor_col    <= tcw_pkg::COL_W'(cur_col);
      cursor_row    <= tcw_pkg::ROW_W'(cur_row);
      cursor_offset <= tcw_pkg::OFF_W'(cur_addr);
      scrolled      <= res_scrolled;
    end
  end

  a_one_sweep: assert property (@(posedge clk) disable iff (rst)
    !(cmd.copy_step && cmd.fill_step))
    else $error("copy and fill sweeps driven together");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status.will_scroll) |=> (cur_row == ROW_LAST) && (cur_col == '0))
    else $error("scrolling put did not leave the cursor at the start of the last row");

endmodule

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RDWAIT = 6'b000100,
    ST_COPY   = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.fill_step        = 1'b1;
        cmd.fill_reset_color = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.exec = 1'b1;
          unique case (status.op)
            tcw_pkg::OP_PUT:   state_next = status.will_scroll ? ST_COPY : ST_RESULT;
            tcw_pkg::OP_MOVE:  state_next = ST_RESULT;
            tcw_pkg::OP_CLEAR: state_next = ST_FILL;
            tcw_pkg::OP_READ:  state_next = ST_RDWAIT;
            default:           state_next = ST_RESULT;
          endcase
        end
      end
      ST_RDWAIT: begin
        cmd.cap_read = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again before the previous item finished");

endmodule

// ----- rtl/text_console_writer.sv -----
// Top level of the text console writer: controller plus datapath with the cell store.
//
// Text-mode console engine with its own store of SCREEN_WIDTH x SCREEN_HEIGHT character
// cells, each 16 bits with the character in bits 7..0 and the attribute in bits 15..8.
// An item carries op (0 put character, 1 move cursor, 2 clear screen, 3 read cell),
// char_code, pos_x and pos_y; every item yields exactly one result item with the cell
// written or read (zero otherwise), the cursor after the item, its linear offset
// row * SCREEN_WIDTH + col (modulo 2048) and a flag that is set when the item scrolled
// the screen. The store has a single write port, so whole-screen work walks it one cell
// per cycle. A clear blanks every cell, and a put that scrolls copies all rows up, then
// blanks the last row. One item is in work at a time; the next item is accepted once the
// result has moved into the output register, even while that result still waits under
// out_stall. After reset the block runs a clearing pass that fills the store with blanks
// in attribute 2; in_stall stays high meanwhile. The attribute register is written
// through cfg_we and cfg_wdata (reset value 2) and should only be written while no item is
// in work.
module text_console_writer #(
  parameter int unsigned SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcw_pkg::OP_W-1:0]     op,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::POS_W-1:0]    pos_x,
  input  logic [tcw_pkg::POS_W-1:0]    pos_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]    cursor_offset,
  output logic                         scrolled
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // The controller sequences each item and the sweeps over the store.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the store, the cursor, the attribute and the result register.
  tcw_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .op            (op),
    .char_code     (char_code),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .cell_data     (cell_data),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_offset (cursor_offset),
    .scrolled      (scrolled)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the text console writer, driving items and checking every result.
`timescale 1ns / 100ps

module testbench;

  // The block is built with its default screen size, so the predictor uses the same one.
  localparam int COLS  = tcw_pkg::SCREEN_WIDTH_DEF;
  localparam int ROWS  = tcw_pkg::SCREEN_HEIGHT_DEF;
  localparam int CELLS = COLS * ROWS;

  // Scrolls and clears each walk the whole store. The random part stops creating them
  // once this many have happened, which keeps the run short.
  localparam int SLOW_BUDGET = 220;

  // Longest stretch with no item accepted on either side. It is set far above the time that
  // a scroll, a clear or the deliberate output hold-off takes.
  localparam int IDLE_LIMIT = 20000;

  // Length of the long output hold-off used to back the block up.
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [tcw_pkg::CELL_W-1:0] cell_word;
    logic [tcw_pkg::COL_W-1:0]  col;
    logic [tcw_pkg::ROW_W-1:0]  row;
    logic [tcw_pkg::OFF_W-1:0]  offset;
    logic                       scrolled_up;
  } console_out_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  tcw_pkg::op_t                 op = tcw_pkg::OP_PUT;
  logic [tcw_pkg::CHAR_W-1:0]   char_code = '0;
  logic [tcw_pkg::POS_W-1:0]    pos_x = '0;
  logic [tcw_pkg::POS_W-1:0]    pos_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [tcw_pkg::CELL_W-1:0]   cell_data;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::OFF_W-1:0]    cursor_offset;
  logic                         scrolled;

  // Predicted state of the console: the cell store, the cursor and the attribute byte.
  logic [tcw_pkg::CELL_W-1:0]   screen [CELLS];
  int                           cur_col;
  int                           cur_row;
  logic [tcw_pkg::COLOR_W-1:0]  text_color;

  // Results that the block still owes, oldest first.
  console_out_t        pending_results[$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int scroll_count  = 0;
  int clear_count   = 0;
  int color_writes  = 0;
  int idle_cycles   = 0;
  int hold_request  = 0;
  bit no_idle       = 1'b0;

  text_console_writer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .char_code     (char_code),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cell_data     (cell_data),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_offset (cursor_offset),
    .scrolled      (scrolled)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Coordinates of move and read items saturate at the screen edge.
  function automatic int clamp_pos(logic [tcw_pkg::POS_W-1:0] v, int limit);
    return (int'(v) > limit - 1) ? limit - 1 : int'(v);
  endfunction

  // Applies one item to the predicted console and returns the result it must produce.
  function automatic console_out_t console_step(tcw_pkg::op_t kind,
                                                logic [tcw_pkg::CHAR_W-1:0] ch,
                                                logic [tcw_pkg::POS_W-1:0] x,
                                                logic [tcw_pkg::POS_W-1:0] y);
    console_out_t res;
    logic [tcw_pkg::CELL_W-1:0] blank;
    int i;
    res = '0;
    blank = {text_color, tcw_pkg::BLANK_CHAR};
    unique case (kind)
      tcw_pkg::OP_PUT: begin
        // A newline only moves the cursor; any other byte lands in the cell at the cursor.
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          res.cell_word = {text_color, ch};
          screen[cur_row * COLS + cur_col] = res.cell_word;
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Falling off the bottom row shifts every row up and blanks the last one.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen[i] = blank;
          cur_row = ROWS - 1;
          res.scrolled_up = 1'b1;
          scroll_count++;
        end
      end
      tcw_pkg::OP_MOVE: begin
        cur_col = clamp_pos(x, COLS);
        cur_row = clamp_pos(y, ROWS);
      end
      tcw_pkg::OP_CLEAR: begin
        // The cursor stays where it is.
        for (i = 0; i < CELLS; i++) screen[i] = blank;
        clear_count++;
      end
      default: begin
        res.cell_word = screen[clamp_pos(y, ROWS) * COLS + clamp_pos(x, COLS)];
      end
    endcase
    res.col    = tcw_pkg::COL_W'(cur_col);
    res.row    = tcw_pkg::ROW_W'(cur_row);
    res.offset = tcw_pkg::OFF_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] error: %s got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Offers one item after a random gap (none while no_idle is set) and holds it until the
  // block takes it. The prediction is made at the accepting edge, so it always sees every earlier item.
  task automatic send_item(tcw_pkg::op_t kind, logic [tcw_pkg::CHAR_W-1:0] ch,
                           logic [tcw_pkg::POS_W-1:0] x, logic [tcw_pkg::POS_W-1:0] y);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    char_code <= ch;
    pos_x     <= x;
    pos_y     <= y;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(console_step(kind, ch, x, y));
    items_sent++;
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The attribute register is only written while nothing is in work.
  task automatic write_text_color(logic [tcw_pkg::COLOR_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    text_color = value;
    color_writes++;
  endtask

  // Random item with realistic weighting: mostly text, with moves and reads scattered
  // through it and the odd clear. Coordinates are usually on screen, sometimes anywhere
  // in the byte range so that clamping and all position bits get exercised.
  task automatic send_random_item;
    int r;
    tcw_pkg::op_t kind;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::POS_W-1:0] x;
    logic [tcw_pkg::POS_W-1:0] y;
    r  = $urandom_range(0, 99);
    ch = tcw_pkg::CHAR_W'($urandom);
    x  = tcw_pkg::POS_W'($urandom);
    y  = tcw_pkg::POS_W'($urandom);
    if (r < 55) begin
      kind = tcw_pkg::OP_PUT;
      if ($urandom_range(0, 9) == 0) ch = tcw_pkg::NEWLINE_CODE;
    end else if (r < 77 && r >= 75) begin
      kind = tcw_pkg::OP_CLEAR;
    end else begin
      kind = (r < 75) ? tcw_pkg::OP_MOVE : tcw_pkg::OP_READ;
      if ($urandom_range(0, 3) != 0) begin
        x = tcw_pkg::POS_W'($urandom_range(0, COLS - 1));
        y = tcw_pkg::POS_W'($urandom_range(0, ROWS - 1));
      end
    end
    // Once the budget of whole-screen operations is spent, anything that would clear
    // or scroll becomes a move to a row above the bottom.
    if (scroll_count + clear_count >= SLOW_BUDGET &&
        (kind == tcw_pkg::OP_CLEAR ||
         (kind == tcw_pkg::OP_PUT && cur_row == ROWS - 1 &&
          (ch == tcw_pkg::NEWLINE_CODE || cur_col == COLS - 1)))) begin
      kind = tcw_pkg::OP_MOVE;
      y = tcw_pkg::POS_W'($urandom_range(0, ROWS - 2));
    end
    send_item(kind, ch, x, y);
  endtask

  // After the power-up clearing pass every cell is a blank in the reset attribute.
  task automatic test_reset_state;
    send_item(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_READ, 8'hFF, tcw_pkg::POS_W'(COLS - 1), tcw_pkg::POS_W'(ROWS - 1));
  endtask

  // Character extremes, the high bit not leaking into the attribute, newline, and a
  // put at the last column wrapping to the next row.
  task automatic test_put_and_wrap;
    send_item(tcw_pkg::OP_PUT, 8'h41, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_PUT, 8'hFF, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_PUT, 8'h80, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_PUT, 8'h00, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_MOVE, 8'h00, tcw_pkg::POS_W'(COLS - 2), 8'd3);
    send_item(tcw_pkg::OP_PUT, 8'h78, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_PUT, 8'h79, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::POS_W'(COLS - 1), 8'd3);
  endtask

  // Coordinates past the edge saturate for both moves and reads.
  task automatic test_clamping;
    send_item(tcw_pkg::OP_MOVE, 8'h00, 8'hFF, 8'hFF);
    send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::POS_W'(COLS), tcw_pkg::POS_W'(ROWS));
    send_item(tcw_pkg::OP_READ, 8'h00, 8'hFF, 8'd0);
    send_item(tcw_pkg::OP_MOVE, 8'h00, tcw_pkg::POS_W'(COLS - 1), tcw_pkg::POS_W'(ROWS - 1));
  endtask

  // Scrolling through a wrap at the bottom right corner and through a newline on the
  // last row; the reads confirm that the rows moved up.
  task automatic test_scroll;
    send_item(tcw_pkg::OP_PUT, 8'h5A, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::POS_W'(COLS - 1), tcw_pkg::POS_W'(ROWS - 2));
    send_item(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::POS_W'(COLS - 1), tcw_pkg::POS_W'(ROWS - 3));
  endtask

  // Clear uses the current attribute for the blanks, and puts pick up a new attribute.
  task automatic test_clear_color;
    write_text_color(8'hFF);
    send_item(tcw_pkg::OP_CLEAR, 8'h00, 8'd0, 8'd0);
    send_item(tcw_pkg::OP_READ, 8'h00, 8'd10, 8'd10);
    write_text_color(8'h00);
    send_item(tcw_pkg::OP_PUT, 8'h51, 8'd0, 8'd0);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the block
  // parks a result in its output register and then stalls its input.
  task automatic test_output_backpressure;
    hold_request = HOLD_CYCLES;
    repeat (12) send_random_item();
    drain();
  endtask

  // Long random runs, each under a different attribute, one of them without idling.
  task automatic test_random_text;
    logic [tcw_pkg::COLOR_W-1:0] colors [6];
    int phase;
    colors = '{8'hA5, 8'h00, 8'hFF, 8'h5A, tcw_pkg::COLOR_W'($urandom), tcw_pkg::RESET_COLOR};
    for (phase = 0; phase < 6; phase++) begin
      write_text_color(colors[phase]);
      no_idle = (phase == 3);
      repeat (250) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Receiver side: draws a stall for each result, or takes a long hold-off once when it
  // is requested, then compares the accepted result with the oldest prediction.
  initial begin : result_checker
    int wait_cycles;
    console_out_t want;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_request > 0 && !hold_done) begin
        wait_cycles = hold_request;
        hold_done   = 1'b1;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cell_data", cell_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (cell_data !== want.cell_word)
          report_mismatch("cell_data", cell_data, want.cell_word);
        if (cursor_col !== want.col) report_mismatch("cursor_col", cursor_col, want.col);
        if (cursor_row !== want.row) report_mismatch("cursor_row", cursor_row, want.row);
        if (cursor_offset !== want.offset)
          report_mismatch("cursor_offset", cursor_offset, want.offset);
        if (scrolled !== want.scrolled_up)
          report_mismatch("scrolled", scrolled, want.scrolled_up);
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without progress", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_sequence
    int i;
    for (i = 0; i < CELLS; i++) screen[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
    text_color = tcw_pkg::RESET_COLOR;
    cur_col = 0;
    cur_row = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_put_and_wrap();
    test_clamping();
    test_scroll();
    test_clear_color();
    test_output_backpressure();
    test_random_text();
    drain();

    $display("Covered %0d items and %0d results, with %0d scrolls and %0d clears,",
             items_sent, results_seen, scroll_count, clear_count);
    $display("over %0d attribute settings and one long output hold-off.", color_writes + 1);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
